### design/dcal_pkg.sv
// dcal_pkg: types, constants and helper functions of the airtime limiter
// used by the channel interfaces, the slot cell and the top level; no dependencies

package dcal_pkg;

   // field widths
   localparam int BYTES_W  = 8;
   localparam int TIME_W   = 32;
   localparam int NEED_W   = 14;
   localparam int BUDGET_W = 16;
   localparam int WINDOW_W = 16;
   localparam int ACK_W    = 13;
   localparam int DUR_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // running sum wide enough for 64 slots of 14 bits each
   localparam int SUM_W = 20;

   // per-frame durations in ms and frame repeat count
   localparam logic [DUR_W-1:0] DUR_ZERO  = 12'd1120;
   localparam logic [DUR_W-1:0] DUR_ONE   = 12'd1200;
   localparam logic [DUR_W-1:0] DUR_SMALL = 12'd1440;
   localparam logic [DUR_W-1:0] DUR_MID   = 12'd1760;
   localparam logic [DUR_W-1:0] DUR_LARGE = 12'd2080;
   localparam logic [1:0]       FRAME_REPEAT = 2'd3;

   // register reset values
   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd36000;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd3600;
   localparam logic [ACK_W-1:0]    ACK_RESET    = 13'd1760;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUDGET = 2'd0,
      CSR_WINDOW = 2'd1,
      CSR_ACK    = 2'd2
   } dcal_csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } dcal_state_type;

   // token handed from cell to cell during the scan
   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] now;
      logic [SUM_W-1:0]  used;
      logic              found;
   } dcal_token_type;

   // commit broadcast to all cells after the decision
   typedef struct packed {
      logic              write;
      logic [TIME_W-1:0] expiry;
      logic [NEED_W-1:0] airtime;
   } dcal_commit_type;

   function automatic logic [DUR_W-1:0] frame_duration(input logic [BYTES_W-1:0] bytes);
      logic [DUR_W-1:0] dur;
      if (bytes == 8'd0) begin
         dur = DUR_ZERO;
      end else if (bytes == 8'd1) begin
         dur = DUR_ONE;
      end else if (bytes < 8'd5) begin
         dur = DUR_SMALL;
      end else if (bytes < 8'd9) begin
         dur = DUR_MID;
      end else begin
         dur = DUR_LARGE;
      end
      return dur;
   endfunction

endpackage

### design/dcal_req_if.sv
// dcal_req_if: request channel, valid/ready with request payload
// depends on dcal_pkg for field widths

interface dcal_req_if;
   import dcal_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTES_W-1:0] payload_bytes;
   logic               want_downlink;
   logic [TIME_W-1:0]  now_time;

   modport source (output valid, output payload_bytes, output want_downlink,
                   output now_time, input ready);
   modport sink   (input valid, input payload_bytes, input want_downlink,
                   input now_time, output ready);
endinterface

### design/dcal_rsp_if.sv
// dcal_rsp_if: response channel, valid/ready with grant and needed airtime
// depends on dcal_pkg for field widths

interface dcal_rsp_if;
   import dcal_pkg::*;

   logic              valid;
   logic              ready;
   logic              granted;
   logic [NEED_W-1:0] needed_ms;

   modport source (output valid, output granted, output needed_ms, input ready);
   modport sink   (input valid, input granted, input needed_ms, output ready);
endinterface

### design/dcal_csr_if.sv
// dcal_csr_if: register write channel, valid/ready with index and data
// depends on dcal_pkg for field widths

interface dcal_csr_if;
   import dcal_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### design/dcal_slot_cell.sv
// dcal_slot_cell: one airtime slot, adds its airtime to the passing token while busy
// and marks itself when it is the first free slot; depends on dcal_pkg

module dcal_slot_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  dcal_pkg::dcal_token_type  tok_in,
   input  dcal_pkg::dcal_commit_type commit,
   output dcal_pkg::dcal_token_type  tok_out,
   output logic                      pend
);
   import dcal_pkg::*;

   logic [TIME_W-1:0] expiry_ff, expiry_in;
   logic [NEED_W-1:0] airtime_ff, airtime_in;
   dcal_token_type    tok_ff, tok_in_next;
   logic              pend_ff, pend_in;
   logic              busy;

   // busy while expiry lies strictly after the token's time
   assign busy = expiry_ff > tok_in.now;

   always_comb begin
      tok_in_next.valid = tok_in.valid;
      tok_in_next.now   = tok_in.now;
      tok_in_next.used  = busy ? tok_in.used + SUM_W'(airtime_ff) : tok_in.used;
      tok_in_next.found = tok_in.found | ~busy;
   end

   always_comb begin
      pend_in = pend_ff;
      if (tok_in.valid) begin
         pend_in = ~busy & ~tok_in.found;
      end
   end

   always_comb begin
      expiry_in  = expiry_ff;
      airtime_in = airtime_ff;
      if (commit.write && pend_ff) begin
         expiry_in  = commit.expiry;
         airtime_in = commit.airtime;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_ff  <= '0;
         airtime_ff <= '0;
         tok_ff     <= '0;
         pend_ff    <= 1'b0;
      end else begin
         expiry_ff  <= expiry_in;
         airtime_ff <= airtime_in;
         tok_ff     <= tok_in_next;
         pend_ff    <= pend_in;
      end
   end

   assign tok_out = tok_ff;
   assign pend    = pend_ff;

endmodule

### design/duty_cycle_airtime_limiter.sv
// duty_cycle_airtime_limiter: sliding-window airtime gate for transmit requests
// depends on dcal_pkg, dcal_req_if, dcal_rsp_if, dcal_csr_if and dcal_slot_cell
//
// usage
//   req: one transfer per transmit attempt (payload size, downlink flag, time)
//   rsp: one transfer per request (granted, needed airtime in ms)
//   csr: register writes, always ready; index 0 budget, 1 window, 2 ack time,
//        other indexes are dropped; write only while the block is idle
// timing
//   a request walks a row of SLOT_COUNT slot cells, one cell per cycle, which
//   sums busy airtime and marks the first free slot; the sum leaving the last
//   cell is compared against the budget and the grant registered; once the
//   output register is free, the response is loaded and, on a grant, the
//   marked slot is written in the same cycle
//   a new request is taken only after the last one has left the decision
//   state; req_ready is high only when idle
// reset
//   synchronous; all slots free with zero airtime, registers at their
//   defaults, no response pending
// stall
//   the response sits in an output register; a new request is taken while it
//   waits, and the decision of that request holds until the register frees

module duty_cycle_airtime_limiter #(
   parameter int SLOT_COUNT = 10
) (
   input  logic       clock,
   input  logic       reset,
   dcal_req_if.sink   req_if,
   dcal_rsp_if.source rsp_if,
   dcal_csr_if.sink   csr_if
);
   import dcal_pkg::*;

   // configuration registers
   logic [BUDGET_W-1:0] budget_ff;
   logic [WINDOW_W-1:0] window_ff;
   logic [ACK_W-1:0]    ack_ff;

   // request context
   logic [TIME_W-1:0]   now_ff;
   logic [NEED_W-1:0]   needed_ff, needed_in;
   logic                grant_ff, grant_in;

   // response output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff;
   logic [NEED_W-1:0]   rsp_needed_ff;

   dcal_state_type      state_ff, state_in;

   // control decoded from state
   logic                req_ready;
   logic                load_rsp;
   logic                req_fire;
   logic                rsp_free;
   logic                last_valid;

   dcal_token_type      tok [SLOT_COUNT+1];
   dcal_commit_type     commit;
   logic [SLOT_COUNT-1:0] pend_vec;
   logic [SLOT_COUNT-1:0] tok_valid_vec;
   logic [SUM_W:0]      total;

   assign csr_if.ready = 1'b1;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
         window_ff <= WINDOW_RESET;
         ack_ff    <= ACK_RESET;
      end else if (csr_if.valid) begin
         unique case (dcal_csr_idx_type'(csr_if.index))
            CSR_BUDGET: budget_ff <= csr_if.data;
            CSR_WINDOW: window_ff <= csr_if.data;
            CSR_ACK:    ack_ff    <= csr_if.data[ACK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_fire = req_if.valid & req_ready;
   assign rsp_free = ~rsp_valid_ff | rsp_if.ready;
   assign last_valid = tok[SLOT_COUNT].valid;

   // needed airtime: frame duration times three plus optional ack time
   always_comb begin
      needed_in = NEED_W'(frame_duration(req_if.payload_bytes)) * NEED_W'(FRAME_REPEAT);
      if (req_if.want_downlink) begin
         needed_in = needed_in + NEED_W'(ack_ff);
      end
   end

   // inject the scan token into the first cell on a request transfer
   always_comb begin
      tok[0].valid = req_fire;
      tok[0].now   = req_if.now_time;
      tok[0].used  = '0;
      tok[0].found = 1'b0;
   end

   // row of slot cells
   for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
      dcal_slot_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[k]),
         .commit  (commit),
         .tok_out (tok[k+1]),
         .pend    (pend_vec[k])
      );
      assign tok_valid_vec[k] = tok[k+1].valid;
   end

   // budget check on the sum leaving the last cell
   assign total    = (SUM_W+1)'(needed_ff) + (SUM_W+1)'(tok[SLOT_COUNT].used);
   assign grant_in = total <= (SUM_W+1)'(budget_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   req_ready = 1'b0;
         ST_DECIDE: load_rsp  = rsp_free;
         default: begin
            req_ready = 1'b0;
            load_rsp  = 1'b0;
         end
      endcase
   end

   assign req_if.ready = req_ready;

   // write the marked free slot on a grant; nothing marked means nothing recorded
   assign commit.write   = load_rsp & grant_ff;
   assign commit.expiry  = now_ff + TIME_W'(window_ff);
   assign commit.airtime = needed_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff    <= req_if.now_time;
         needed_ff <= needed_in;
      end
      if (state_ff == ST_SCAN && last_valid) begin
         grant_ff <= grant_in;
      end
      if (load_rsp) begin
         rsp_granted_ff <= grant_ff;
         rsp_needed_ff  <= needed_ff;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.granted   = rsp_granted_ff;
   assign rsp_if.needed_ms = rsp_needed_ff;

   // after a request transfer, the scan token reaches the end of the row
   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ##SLOT_COUNT last_valid)
      else $error("scan token did not leave the last cell on time");

   // once the scan is complete, at most one slot is marked as first free
   a_one_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |-> $onehot0(pend_vec))
      else $error("more than one slot marked free");

   // at most one request in the cell row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid_vec))
      else $error("more than one scan token in flight");

   // a response appears only out of the decision state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DECIDE))
      else $error("response loaded outside the decision");

endmodule
